// ===== design/assert_macros.svh =====
// Assertion macros shared by the ray border intersection design.
// Depends on nothing; the clock i_clk and reset i_rst_n are taken from the user scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define RBI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RBI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RBI_ASSERT_IMP(lbl, ante, cons, msg)
`define RBI_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/rbi_pkg.sv =====
// Types, constants and helpers for the ray border intersection pipeline.
// Depends on nothing.
package rbi_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int COORD_BITS = 24;
    localparam int DIR_W      = COORD_BITS + 1;      // direction after negation
    localparam int MAG_W      = COORD_BITS;          // magnitude of direction / numerator
    localparam int T_W        = 28;                  // ray parameter width
    localparam int N_W        = MAG_W + FRAC_BITS;   // shifted numerator
    localparam int HEAD_W     = N_W - T_W;           // numerator bits above quotient
    localparam int CELLS      = T_W;                 // one quotient bit per cell
    localparam int NSTAGE     = CELLS + 4;           // front, cells, min, multiply, walk
    localparam int LANES      = 4;
    localparam int LIM_W      = 12;
    localparam int SIZE_W     = 13;
    localparam int PROD_W     = MAG_W + T_W;
    localparam logic [T_W-1:0] T_SENTINEL = T_W'(1000000 * (1 << FRAC_BITS));
    localparam logic [SIZE_W-1:0] FRAME_MAX = SIZE_W'(4096);

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] dir_x;
        logic signed [COORD_BITS-1:0] dir_y;
        logic                         reverse_dir;
    } t_in;

    typedef struct packed {
        logic [LIM_W-1:0] hit_x;
        logic [LIM_W-1:0] hit_y;
    } t_out;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic signed [DIR_W-1:0]      dx;
        logic signed [DIR_W-1:0]      dy;
    } t_ray;

    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [T_W-1:0]   low;
        logic [T_W-1:0]   quo;
        logic [MAG_W-1:0] dvs;
        logic             sat;
    } t_lane;

    typedef struct packed {
        t_ray                  ray;
        t_lane [LANES-1:0]     lane;
    } t_div;

    function automatic logic [LIM_W-1:0] border_lim(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] s;
        s = size;
        if (s == '0) s = SIZE_W'(1);
        if (s > FRAME_MAX) s = FRAME_MAX;
        border_lim = LIM_W'(s - SIZE_W'(1));
    endfunction

endpackage

// ===== design/rbi_front.sv =====
// Entry stage: applies the reverse flag and sets up the four border divisions.
// Depends on rbi_pkg.
module rbi_front (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  rbi_pkg::t_in                 i_data,
    input  logic [rbi_pkg::LIM_W-1:0]    i_wlim,
    input  logic [rbi_pkg::LIM_W-1:0]    i_hlim,
    output rbi_pkg::t_div                o_div
);

    localparam int NUM_W = rbi_pkg::COORD_BITS + 2;

    rbi_pkg::t_div r_div;
    rbi_pkg::t_div n_div;

    function automatic rbi_pkg::t_lane setup_lane(input logic signed [NUM_W-1:0] num,
                                                  input logic signed [rbi_pkg::DIR_W-1:0] d);
        rbi_pkg::t_lane              l;
        logic [NUM_W-1:0]            nabs;
        logic [rbi_pkg::DIR_W-1:0]   dabs;
        logic [rbi_pkg::N_W-1:0]     nsh;
        logic                        force_sat;
        logic                        ovf;
        nabs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        dabs = d[rbi_pkg::DIR_W-1] ? rbi_pkg::DIR_W'(-d) : rbi_pkg::DIR_W'(d);
        nsh  = {nabs[rbi_pkg::MAG_W-1:0], {rbi_pkg::FRAC_BITS{1'b0}}};
        force_sat = (d == '0) ||
                    ((num != '0) && (num[NUM_W-1] != d[rbi_pkg::DIR_W-1]));
        // quotient would need more than T_W bits: above the sentinel anyway
        ovf = rbi_pkg::MAG_W'(nsh[rbi_pkg::N_W-1 -: rbi_pkg::HEAD_W])
              >= dabs[rbi_pkg::MAG_W-1:0];
        l.rem = rbi_pkg::MAG_W'(nsh[rbi_pkg::N_W-1 -: rbi_pkg::HEAD_W]);
        l.low = nsh[rbi_pkg::T_W-1:0];
        l.quo = '0;
        l.dvs = dabs[rbi_pkg::MAG_W-1:0];
        l.sat = force_sat || ovf;
        setup_lane = l;
    endfunction

    always_comb begin
        logic signed [rbi_pkg::DIR_W-1:0] dx;
        logic signed [rbi_pkg::DIR_W-1:0] dy;
        logic signed [NUM_W-1:0]          px;
        logic signed [NUM_W-1:0]          py;
        logic signed [NUM_W-1:0]          wb;
        logic signed [NUM_W-1:0]          hb;
        dx = rbi_pkg::DIR_W'(i_data.dir_x);
        dy = rbi_pkg::DIR_W'(i_data.dir_y);
        if (i_data.reverse_dir) begin
            dx = -dx;
            dy = -dy;
        end
        px = NUM_W'(i_data.pos_x);
        py = NUM_W'(i_data.pos_y);
        wb = NUM_W'({i_wlim, {rbi_pkg::FRAC_BITS{1'b0}}});
        hb = NUM_W'({i_hlim, {rbi_pkg::FRAC_BITS{1'b0}}});
        n_div.ray.px = i_data.pos_x;
        n_div.ray.py = i_data.pos_y;
        n_div.ray.dx = dx;
        n_div.ray.dy = dy;
        n_div.lane[0] = setup_lane(-px, dx);
        n_div.lane[1] = setup_lane(wb - px, dx);
        n_div.lane[2] = setup_lane(-py, dy);
        n_div.lane[3] = setup_lane(hb - py, dy);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

// ===== design/rbi_div_cell.sv =====
// Divider cell: resolves one quotient bit for all four border lanes.
// Depends on rbi_pkg.
module rbi_div_cell (
    input  logic          i_clk,
    input  logic          i_en,
    input  rbi_pkg::t_div i_div,
    output rbi_pkg::t_div o_div
);

    rbi_pkg::t_div r_div;
    rbi_pkg::t_div n_div;

    always_comb begin
        n_div.ray = i_div.ray;
        for (int k = 0; k < rbi_pkg::LANES; k++) begin
            logic [rbi_pkg::MAG_W:0] trial;
            logic [rbi_pkg::MAG_W:0] diff;
            logic                    ge;
            trial = {i_div.lane[k].rem, i_div.lane[k].low[rbi_pkg::T_W-1]};
            diff  = trial - {1'b0, i_div.lane[k].dvs};
            ge    = trial >= {1'b0, i_div.lane[k].dvs};
            n_div.lane[k].rem = ge ? diff[rbi_pkg::MAG_W-1:0] : trial[rbi_pkg::MAG_W-1:0];
            n_div.lane[k].low = {i_div.lane[k].low[rbi_pkg::T_W-2:0], 1'b0};
            n_div.lane[k].quo = {i_div.lane[k].quo[rbi_pkg::T_W-2:0], ge};
            n_div.lane[k].dvs = i_div.lane[k].dvs;
            n_div.lane[k].sat = i_div.lane[k].sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

// ===== design/rbi_back.sv =====
// Back end: least parameter, walk products, then truncate and clamp into the frame.
// Depends on rbi_pkg.
module rbi_back (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  rbi_pkg::t_div             i_div,
    input  logic [rbi_pkg::LIM_W-1:0] i_wlim,
    input  logic [rbi_pkg::LIM_W-1:0] i_hlim,
    output rbi_pkg::t_out             o_hit
);

    localparam int S_W = rbi_pkg::PROD_W + 2;

    logic [rbi_pkg::T_W-1:0]    r_t;
    rbi_pkg::t_ray              r_ray_a;
    logic [rbi_pkg::PROD_W-1:0] r_mx;
    logic [rbi_pkg::PROD_W-1:0] r_my;
    rbi_pkg::t_ray              r_ray_b;
    rbi_pkg::t_out              r_hit;

    logic [rbi_pkg::T_W-1:0]    n_t;
    logic [rbi_pkg::PROD_W-1:0] n_mx;
    logic [rbi_pkg::PROD_W-1:0] n_my;
    rbi_pkg::t_out              n_hit;

    function automatic logic [rbi_pkg::MAG_W-1:0] dmag(input logic signed [rbi_pkg::DIR_W-1:0] d);
        logic [rbi_pkg::DIR_W-1:0] a;
        a = d[rbi_pkg::DIR_W-1] ? rbi_pkg::DIR_W'(-d) : rbi_pkg::DIR_W'(d);
        dmag = a[rbi_pkg::MAG_W-1:0];
    endfunction

    function automatic logic [rbi_pkg::LIM_W-1:0] walk(
        input logic signed [rbi_pkg::COORD_BITS-1:0] p,
        input logic                                  dneg,
        input logic [rbi_pkg::PROD_W-1:0]            mag,
        input logic [rbi_pkg::LIM_W-1:0]             lim);
        logic signed [S_W-1:0]              sp;
        logic signed [S_W-1:0]              sm;
        logic signed [S_W-1:0]              s;
        logic [S_W-2*rbi_pkg::FRAC_BITS-1:0] q;
        sp = S_W'(p) <<< rbi_pkg::FRAC_BITS;
        sm = S_W'({2'b00, mag});
        s  = dneg ? sp - sm : sp + sm;
        q  = s[S_W-1:2*rbi_pkg::FRAC_BITS];
        if (s[S_W-1]) walk = '0;
        else if (q > (S_W-2*rbi_pkg::FRAC_BITS)'(lim)) walk = lim;
        else walk = q[rbi_pkg::LIM_W-1:0];
    endfunction

    always_comb begin
        logic [rbi_pkg::T_W-1:0] tl [rbi_pkg::LANES];
        logic [rbi_pkg::T_W-1:0] m01;
        logic [rbi_pkg::T_W-1:0] m23;
        for (int k = 0; k < rbi_pkg::LANES; k++) begin
            tl[k] = (i_div.lane[k].sat || (i_div.lane[k].quo > rbi_pkg::T_SENTINEL))
                    ? rbi_pkg::T_SENTINEL : i_div.lane[k].quo;
        end
        m01 = (tl[0] < tl[1]) ? tl[0] : tl[1];
        m23 = (tl[2] < tl[3]) ? tl[2] : tl[3];
        n_t = (m01 < m23) ? m01 : m23;
    end

    assign n_mx = rbi_pkg::PROD_W'(dmag(r_ray_a.dx)) * rbi_pkg::PROD_W'(r_t);
    assign n_my = rbi_pkg::PROD_W'(dmag(r_ray_a.dy)) * rbi_pkg::PROD_W'(r_t);

    assign n_hit.hit_x = walk(r_ray_b.px, r_ray_b.dx[rbi_pkg::DIR_W-1], r_mx, i_wlim);
    assign n_hit.hit_y = walk(r_ray_b.py, r_ray_b.dy[rbi_pkg::DIR_W-1], r_my, i_hlim);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t     <= n_t;
            r_ray_a <= i_div.ray;
            r_mx    <= n_mx;
            r_my    <= n_my;
            r_ray_b <= r_ray_a;
            r_hit   <= n_hit;
        end
    end

    assign o_hit = r_hit;

endmodule

// ===== design/ray_border_intersection.sv =====
// Ray border intersection: one ray per cycle while o_stall is low.
// The depth is set by the divider chain of 28 cells, one quotient bit each, plus entry,
// minimum, multiply, walk and output registers. A skid register behind the pipeline
// takes one result while the output is stalled. Synchronous active-low reset empties
// the pipeline and sets frame width 640 and height 480. Depends on rbi_pkg and the macros.
`include "assert_macros.svh"
module ray_border_intersection (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  rbi_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output rbi_pkg::t_out o_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [rbi_pkg::SIZE_W-1:0] r_width;
    logic [rbi_pkg::SIZE_W-1:0] r_height;
    logic [rbi_pkg::LIM_W-1:0]  wlim;
    logic [rbi_pkg::LIM_W-1:0]  hlim;

    logic [rbi_pkg::NSTAGE-1:0] r_vld;
    logic                       en;
    rbi_pkg::t_div              w_div [rbi_pkg::CELLS+1];
    rbi_pkg::t_out              pipe_hit;
    logic                       pipe_vld;

    rbi_pkg::t_out r_out;
    rbi_pkg::t_out r_skid;
    logic          r_ov;
    logic          r_sv;

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr[2] == rbi_pkg::REG_HEIGHT) ? 32'(r_height) : 32'(r_width);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= rbi_pkg::SIZE_W'(640);
            r_height <= rbi_pkg::SIZE_W'(480);
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                rbi_pkg::REG_WIDTH:  r_width  <= pwdata[rbi_pkg::SIZE_W-1:0];
                rbi_pkg::REG_HEIGHT: r_height <= pwdata[rbi_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    assign wlim = rbi_pkg::border_lim(r_width);
    assign hlim = rbi_pkg::border_lim(r_height);

    // the whole pipeline holds only while the skid register is occupied
    assign en       = !r_sv;
    assign o_stall  = r_sv;
    assign pipe_vld = r_vld[rbi_pkg::NSTAGE-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[rbi_pkg::NSTAGE-2:0], i_valid};
        end
    end

    rbi_front u_front (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_data (i_data),
        .i_wlim (wlim),
        .i_hlim (hlim),
        .o_div  (w_div[0])
    );

    for (genvar g = 0; g < rbi_pkg::CELLS; g++) begin : g_cell
        rbi_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_div (w_div[g]),
            .o_div (w_div[g+1])
        );
    end

    rbi_back u_back (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_div  (w_div[rbi_pkg::CELLS]),
        .i_wlim (wlim),
        .i_hlim (hlim),
        .o_hit  (pipe_hit)
    );

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || !i_stall) begin
            r_ov <= r_sv || pipe_vld;
            r_sv <= 1'b0;
        end else if (pipe_vld && en) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || !i_stall) begin
            r_out <= r_sv ? r_skid : pipe_hit;
        end else if (pipe_vld && en) begin
            r_skid <= pipe_hit;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

    `RBI_ASSERT_IMP(a_skid_behind_out, r_sv, r_ov, "skid occupied without output")
    `RBI_ASSERT_IMP(a_skid_fill, $rose(r_sv), $past(r_ov && i_stall), "skid filled while not stalled")
    `RBI_ASSERT_NXT(a_skid_take, r_ov && i_stall && !r_sv && pipe_vld, r_sv, "result dropped")
    `RBI_ASSERT_IMP(a_hit_in_frame, r_ov, (r_out.hit_x <= wlim) && (r_out.hit_y <= hlim), "hit off frame")

endmodule
